/* rtl/ewr_pkg.sv */
// ----------------------------------------------------------------------------
// ewr_pkg
// Shared widths, request kinds and register indexes of the exponentially
// weighted pair-regression residual block.
// ----------------------------------------------------------------------------
package ewr_pkg;

   localparam int PRICE_W = 32;
   localparam int MEAN_W  = 40;
   localparam int SQ_W    = 64;
   localparam int DEC_W   = 16;
   localparam int KIND_W  = 3;
   localparam int RES_W   = 32;
   localparam int ACC_W   = 82;

   localparam int MUL_A_W = 64;
   localparam int MUL_B_W = 40;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int DIV_N_W = MUL_P_W;
   localparam int DIV_D_W = SQ_W;

   localparam int CSR_IDX_W = 2;

   localparam logic [KIND_W-1:0] KIND_DEP    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_INDEP  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_JUMP   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_INTR   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_RESUME = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_TIME_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEP_DECAY   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEP_DECAY = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_JOINT_DECAY = 2'd3;

   localparam logic [DEC_W-1:0] DECAY_RESET = 16'd62259;

endpackage

/* rtl/ewr_mul.sv */
// ----------------------------------------------------------------------------
// ewr_mul
// Bit-serial shift-and-add multiplier: one multiplier bit per cycle, the
// product shifting out through the low register.
// ----------------------------------------------------------------------------
module ewr_mul
   import ewr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [MUL_A_W-1:0] a,
   input  logic [MUL_B_W-1:0] b,
   output logic               done,
   output logic [MUL_P_W-1:0] prod
);

   localparam int CNT_W = $clog2(MUL_B_W);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(MUL_B_W - 1);

   logic [MUL_A_W-1:0] a_ff, a_in;
   logic [MUL_A_W-1:0] hi_ff, hi_in;
   logic [MUL_B_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [MUL_A_W:0]   sum;

   always_comb begin
      sum     = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : '0);
      a_in    = a_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = a;
         hi_in   = '0;
         lo_in   = b;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         hi_in  = sum[MUL_A_W:1];
         lo_in  = {sum[0], lo_ff[MUL_B_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign prod = {hi_ff, lo_ff};

endmodule

/* rtl/ewr_div.sv */
// ----------------------------------------------------------------------------
// ewr_div
// Restoring divider: one quotient bit per cycle, quotient bits shifting in
// behind the numerator, truncating toward zero.
// ----------------------------------------------------------------------------
module ewr_div
   import ewr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DIV_N_W-1:0] num,
   input  logic [DIV_D_W-1:0] den,
   output logic               done,
   output logic [DIV_N_W-1:0] quot
);

   localparam int CNT_W = $clog2(DIV_N_W);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_N_W - 1);

   logic [DIV_N_W-1:0] n_ff, n_in;
   logic [DIV_D_W-1:0] den_ff, den_in;
   logic [DIV_D_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DIV_D_W:0]   part;
   logic [DIV_D_W:0]   diff;
   logic               ge;

   always_comb begin
      part    = {rem_ff, n_ff[DIV_N_W-1]};
      diff    = part - {1'b0, den_ff};
      ge      = part >= {1'b0, den_ff};
      n_in    = n_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         n_in    = num;
         den_in  = den;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIV_D_W-1:0] : part[DIV_D_W-1:0];
         n_in   = {n_ff[DIV_N_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quot = n_ff;

endmodule

/* rtl/ewma_pair_regression_residual.sv */
// ----------------------------------------------------------------------------
// ewma_pair_regression_residual
// Exponentially weighted regression of a dependent price on an independent
// price, giving a saturated Q23.8 residual on each price update.
// ----------------------------------------------------------------------------
// One request is worked on at a time; req_stall is high from acceptance until
// the sequencer is back in idle. All products go through one bit-serial
// multiplier and the projection through one bit-serial divider. A ready price
// update takes two product multiplies, two multiplies per mean blended (four
// means in plain mode; in time mode two for a dependent price and three for an
// independent one), then, unless the square mean is at most ONE_Q16 or an
// interrupt is pending, one more multiply, the divide and rounding. Seeding
// and a jump each take two multiplies. The finished result sits in the output
// register, so a new request is taken while it waits.
// ----------------------------------------------------------------------------
module ewma_pair_regression_residual
   import ewr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [KIND_W-1:0]        req_kind,
   input  logic [PRICE_W-1:0]       req_price,
   input  logic [PRICE_W-1:0]       req_old_price,
   input  logic                     req_sources_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [RES_W-1:0]  rsp_residual,
   input  logic                     csr_wen,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DEC_W-1:0]         csr_wdata
);

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_DEC    = 5'd1;
   localparam logic [4:0] S_SEED_A = 5'd2;
   localparam logic [4:0] S_SEED_B = 5'd3;
   localparam logic [4:0] S_SEED_C = 5'd4;
   localparam logic [4:0] S_UPD_A  = 5'd5;
   localparam logic [4:0] S_UPD_B  = 5'd6;
   localparam logic [4:0] S_UPD_C  = 5'd7;
   localparam logic [4:0] S_BL_SEL = 5'd8;
   localparam logic [4:0] S_BL_X   = 5'd9;
   localparam logic [4:0] S_BL_M   = 5'd10;
   localparam logic [4:0] S_RES    = 5'd11;
   localparam logic [4:0] S_RES_M  = 5'd12;
   localparam logic [4:0] S_RES_D  = 5'd13;
   localparam logic [4:0] S_RES_F1 = 5'd14;
   localparam logic [4:0] S_RES_F2 = 5'd15;
   localparam logic [4:0] S_RES_F3 = 5'd16;
   localparam logic [4:0] S_RES_F4 = 5'd17;
   localparam logic [4:0] S_JMP_A  = 5'd18;
   localparam logic [4:0] S_JMP_C  = 5'd19;
   localparam logic [4:0] S_JMP_D  = 5'd20;
   localparam logic [4:0] S_JMP_E  = 5'd21;
   localparam logic [4:0] S_JMP_F  = 5'd22;
   localparam logic [4:0] S_OUT    = 5'd23;

   localparam logic [SQ_W-1:0] ONE_Q16  = 64'd65536;
   localparam logic [SQ_W-1:0] QUOT_CAP = 64'h4000_0000_0000_0000;

   function automatic logic [SQ_W-1:0] sat_apply(input logic [SQ_W-1:0] acc,
                                                 input logic neg,
                                                 input logic [ACC_W-1:0] mag);
      logic [SQ_W:0]   s;
      logic [SQ_W-1:0] r;
      begin
         s = {1'b0, acc} + {1'b0, mag[SQ_W-1:0]};
         if (!neg) begin
            if (mag[ACC_W-1:SQ_W] != '0 || s[SQ_W]) r = '1;
            else r = s[SQ_W-1:0];
         end else begin
            if (mag[ACC_W-1:SQ_W] != '0 || mag[SQ_W-1:0] > acc) r = '0;
            else r = acc - mag[SQ_W-1:0];
         end
         sat_apply = r;
      end
   endfunction

   // architectural state
   logic [4:0]          state_ff, state_in;
   logic                tm_ff, tm_in;
   logic [DEC_W-1:0]    dep_dec_ff, dep_dec_in;
   logic [DEC_W-1:0]    ind_dec_ff, ind_dec_in;
   logic [DEC_W-1:0]    jnt_dec_ff, jnt_dec_in;
   logic                ready_ff, ready_in;
   logic                intr_ff, intr_in;
   logic [PRICE_W-1:0]  dep_px_ff, dep_px_in;
   logic [PRICE_W-1:0]  ind_px_ff, ind_px_in;
   logic [MEAN_W-1:0]   dep_mean_ff, dep_mean_in;
   logic [MEAN_W-1:0]   ind_mean_ff, ind_mean_in;
   logic [SQ_W-1:0]     cross_ff, cross_in;
   logic [SQ_W-1:0]     square_ff, square_in;
   logic [1:0]          sel_ff, sel_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [PRICE_W-1:0]  price_ff, price_in;
   logic [PRICE_W-1:0]  old_ff, old_in;
   logic                src_ff, src_in;
   logic [SQ_W-1:0]     pdi_ff, pdi_in;
   logic [SQ_W-1:0]     pii_ff, pii_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [SQ_W-1:0]     wk_ff, wk_in;
   logic                xneg_ff, xneg_in;
   logic                rneg_ff, rneg_in;
   logic                jneg_ff, jneg_in;
   logic                sneg_ff, sneg_in;
   logic [PRICE_W-1:0]  jm_ff, jm_in;
   logic [RES_W-1:0]    res_ff, res_in;
   logic [RES_W-1:0]    rsp_res_ff, rsp_res_in;

   // shared units
   logic                mul_start, mul_done;
   logic [MUL_A_W-1:0]  mul_a;
   logic [MUL_B_W-1:0]  mul_b;
   logic [MUL_P_W-1:0]  mul_prod;
   logic                div_start, div_done;
   logic [DIV_N_W-1:0]  div_quot;

   // datapath terms
   logic                bl_en;
   logic [SQ_W-1:0]     bl_x;
   logic [SQ_W-1:0]     bl_m;
   logic [DEC_W-1:0]    bl_d;
   logic [DEC_W:0]      bl_w;
   logic [ACC_W-1:0]    bl_sum;
   logic [SQ_W-1:0]     bl_new;
   logic [MEAN_W-1:0]   ind16;
   logic [MEAN_W-1:0]   dep16;
   logic                xneg;
   logic [MEAN_W-1:0]   xm;
   logic [SQ_W-1:0]     qc;
   logic [SQ_W-1:0]     rnd;
   logic [55:0]         mag;
   logic [ACC_W-1:0]    prod_rnd;
   logic                jneg;
   logic [PRICE_W-1:0]  jm;
   logic [MEAN_W-1:0]   j16;
   logic [MEAN_W:0]     twice;
   logic [MEAN_W+1:0]   e;
   logic                eneg;
   logic [MEAN_W:0]     ind_up;

   ewr_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   ewr_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (mul_prod),
      .den   (square_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // blend operand selection: dep mean, indep mean, square mean, cross mean
   always_comb begin
      case (sel_ff)
         2'd0: begin
            bl_en = !tm_ff || kind_ff == KIND_DEP;
            bl_x  = {24'd0, dep_px_ff, 8'd0};
            bl_m  = {24'd0, dep_mean_ff};
            bl_d  = dep_dec_ff;
         end
         2'd1: begin
            bl_en = !tm_ff || kind_ff == KIND_INDEP;
            bl_x  = {24'd0, ind_px_ff, 8'd0};
            bl_m  = {24'd0, ind_mean_ff};
            bl_d  = tm_ff ? ind_dec_ff : dep_dec_ff;
         end
         2'd2: begin
            bl_en = !tm_ff || kind_ff == KIND_INDEP;
            bl_x  = pii_ff;
            bl_m  = square_ff;
            bl_d  = tm_ff ? ind_dec_ff : dep_dec_ff;
         end
         default: begin
            bl_en = 1'b1;
            bl_x  = pdi_ff;
            bl_m  = cross_ff;
            bl_d  = tm_ff ? jnt_dec_ff : dep_dec_ff;
         end
      endcase
      bl_w   = 17'h10000 - {1'b0, bl_d};
      bl_sum = acc_ff + mul_prod[ACC_W-1:0] + 82'd32768;
      bl_new = bl_sum[79:16];
   end

   always_comb begin
      ind16 = {ind_px_ff, 8'd0};
      dep16 = {dep_px_ff, 8'd0};
      xneg  = ind16 < ind_mean_ff;
      xm    = xneg ? ind_mean_ff - ind16 : ind16 - ind_mean_ff;
      if (div_quot[DIV_N_W-1:63] != '0 || (div_quot[62] && div_quot[61:0] != '0))
         qc = QUOT_CAP;
      else
         qc = div_quot[SQ_W-1:0];
      rnd      = wk_ff + 64'd128;
      mag      = rnd[63:8];
      prod_rnd = (mul_prod[ACC_W-1:0] + 82'd128) >> 8;

      // jump terms
      jneg  = price_ff < old_ff;
      jm    = jneg ? old_ff - price_ff : price_ff - old_ff;
      j16   = {jm, 8'd0};
      twice = {ind_mean_ff, 1'b0};
      eneg  = 1'b0;
      if (!jneg) begin
         e = {1'b0, twice} + {2'b00, j16};
      end else if (twice >= {1'b0, j16}) begin
         e = {1'b0, twice - {1'b0, j16}};
      end else begin
         e    = {1'b0, {1'b0, j16} - twice};
         eneg = 1'b1;
      end
      ind_up = {1'b0, ind_mean_ff} + {1'b0, j16};
   end

   always_comb begin
      state_in     = state_ff;
      tm_in        = tm_ff;
      dep_dec_in   = dep_dec_ff;
      ind_dec_in   = ind_dec_ff;
      jnt_dec_in   = jnt_dec_ff;
      ready_in     = ready_ff;
      intr_in      = intr_ff;
      dep_px_in    = dep_px_ff;
      ind_px_in    = ind_px_ff;
      dep_mean_in  = dep_mean_ff;
      ind_mean_in  = ind_mean_ff;
      cross_in     = cross_ff;
      square_in    = square_ff;
      sel_in       = sel_ff;
      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      price_in     = price_ff;
      old_in       = old_ff;
      src_in       = src_ff;
      pdi_in       = pdi_ff;
      pii_in       = pii_ff;
      acc_in       = acc_ff;
      wk_in        = wk_ff;
      xneg_in      = xneg_ff;
      rneg_in      = rneg_ff;
      jneg_in      = jneg_ff;
      sneg_in      = sneg_ff;
      jm_in        = jm_ff;
      res_in       = res_ff;
      rsp_res_in   = rsp_res_ff;
      mul_start    = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;

      if (csr_wen) begin
         case (csr_index)
            CSR_TIME_MODE:   tm_in      = csr_wdata[0];
            CSR_DEP_DECAY:   dep_dec_in = csr_wdata;
            CSR_INDEP_DECAY: ind_dec_in = csr_wdata;
            CSR_JOINT_DECAY: jnt_dec_in = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in  = req_kind;
               price_in = req_price;
               old_in   = req_old_price;
               src_in   = req_sources_ready;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            case (kind_ff)
               KIND_INTR: begin
                  intr_in  = 1'b1;
                  res_in   = '0;
                  state_in = S_OUT;
               end
               KIND_RESUME: begin
                  intr_in  = 1'b0;
                  state_in = S_SEED_A;
               end
               KIND_JUMP: state_in = S_JMP_A;
               KIND_DEP, KIND_INDEP: begin
                  if (kind_ff == KIND_DEP) dep_px_in = price_ff;
                  else ind_px_in = price_ff;
                  if (ready_ff) begin
                     state_in = S_UPD_A;
                  end else if (src_ff) begin
                     ready_in = 1'b1;
                     state_in = S_SEED_A;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_SEED_A: begin
            dep_mean_in = dep16;
            ind_mean_in = ind16;
            mul_start   = 1'b1;
            mul_a       = {32'd0, dep_px_ff};
            mul_b       = {8'd0, ind_px_ff};
            state_in    = S_SEED_B;
         end
         S_SEED_B: begin
            if (mul_done) begin
               cross_in  = mul_prod[SQ_W-1:0];
               mul_start = 1'b1;
               mul_a     = {32'd0, ind_px_ff};
               mul_b     = {8'd0, ind_px_ff};
               state_in  = S_SEED_C;
            end
         end
         S_SEED_C: begin
            if (mul_done) begin
               square_in = mul_prod[SQ_W-1:0];
               state_in  = S_IDLE;
            end
         end
         S_UPD_A: begin
            mul_start = 1'b1;
            mul_a     = {32'd0, dep_px_ff};
            mul_b     = {8'd0, ind_px_ff};
            state_in  = S_UPD_B;
         end
         S_UPD_B: begin
            if (mul_done) begin
               pdi_in    = mul_prod[SQ_W-1:0];
               mul_start = 1'b1;
               mul_a     = {32'd0, ind_px_ff};
               mul_b     = {8'd0, ind_px_ff};
               state_in  = S_UPD_C;
            end
         end
         S_UPD_C: begin
            if (mul_done) begin
               pii_in   = mul_prod[SQ_W-1:0];
               sel_in   = 2'd0;
               state_in = S_BL_SEL;
            end
         end
         S_BL_SEL: begin
            if (bl_en) begin
               mul_start = 1'b1;
               mul_a     = bl_x;
               mul_b     = {23'd0, bl_w};
               state_in  = S_BL_X;
            end else begin
               sel_in = sel_ff + 2'd1;
            end
         end
         S_BL_X: begin
            if (mul_done) begin
               acc_in    = mul_prod[ACC_W-1:0];
               mul_start = 1'b1;
               mul_a     = bl_m;
               mul_b     = {24'd0, bl_d};
               state_in  = S_BL_M;
            end
         end
         S_BL_M: begin
            if (mul_done) begin
               case (sel_ff)
                  2'd0:    dep_mean_in = bl_new[MEAN_W-1:0];
                  2'd1:    ind_mean_in = bl_new[MEAN_W-1:0];
                  2'd2:    square_in   = bl_new;
                  default: cross_in    = bl_new;
               endcase
               if (sel_ff == 2'd3) begin
                  state_in = S_RES;
               end else begin
                  sel_in   = sel_ff + 2'd1;
                  state_in = S_BL_SEL;
               end
            end
         end
         S_RES: begin
            if (square_ff <= ONE_Q16 || intr_ff) begin
               res_in   = '0;
               state_in = S_OUT;
            end else begin
               xneg_in   = xneg;
               mul_start = 1'b1;
               mul_a     = cross_ff;
               mul_b     = xm;
               state_in  = S_RES_M;
            end
         end
         S_RES_M: begin
            if (mul_done) begin
               div_start = 1'b1;
               state_in  = S_RES_D;
            end
         end
         S_RES_D: begin
            if (div_done) begin
               wk_in    = xneg_ff ? 64'd0 - qc : qc;
               state_in = S_RES_F1;
            end
         end
         S_RES_F1: begin
            wk_in    = wk_ff + {24'd0, dep_mean_ff};
            state_in = S_RES_F2;
         end
         S_RES_F2: begin
            wk_in    = wk_ff - {24'd0, dep16};
            state_in = S_RES_F3;
         end
         S_RES_F3: begin
            rneg_in  = wk_ff[SQ_W-1];
            wk_in    = wk_ff[SQ_W-1] ? 64'd0 - wk_ff : wk_ff;
            state_in = S_RES_F4;
         end
         S_RES_F4: begin
            if (rneg_ff) begin
               if (mag > 56'h80000000) res_in = 32'h80000000;
               else res_in = 32'd0 - mag[RES_W-1:0];
            end else begin
               if (mag > 56'h7FFFFFFF) res_in = 32'h7FFFFFFF;
               else res_in = mag[RES_W-1:0];
            end
            state_in = S_OUT;
         end
         S_JMP_A: begin
            jneg_in   = jneg;
            sneg_in   = jneg ^ eneg;
            jm_in     = jm;
            ind_px_in = price_ff;
            if (jneg) ind_mean_in = (j16 > ind_mean_ff) ? '0 : ind_mean_ff - j16;
            else ind_mean_in = ind_up[MEAN_W] ? '1 : ind_up[MEAN_W-1:0];
            mul_start = 1'b1;
            mul_a     = {22'd0, e};
            mul_b     = {8'd0, jm};
            state_in  = S_JMP_C;
         end
         S_JMP_C: begin
            if (mul_done) begin
               acc_in   = prod_rnd;
               state_in = S_JMP_D;
            end
         end
         S_JMP_D: begin
            square_in = sat_apply(square_ff, sneg_ff, acc_ff);
            mul_start = 1'b1;
            mul_a     = {24'd0, dep_mean_ff};
            mul_b     = {8'd0, jm_ff};
            state_in  = S_JMP_E;
         end
         S_JMP_E: begin
            if (mul_done) begin
               acc_in   = prod_rnd;
               state_in = S_JMP_F;
            end
         end
         S_JMP_F: begin
            cross_in = sat_apply(cross_ff, jneg_ff, acc_ff);
            state_in = S_IDLE;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_res_in   = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tm_ff        <= 1'b0;
         dep_dec_ff   <= DECAY_RESET;
         ind_dec_ff   <= DECAY_RESET;
         jnt_dec_ff   <= DECAY_RESET;
         ready_ff     <= 1'b0;
         intr_ff      <= 1'b0;
         dep_px_ff    <= '0;
         ind_px_ff    <= '0;
         dep_mean_ff  <= '0;
         ind_mean_ff  <= '0;
         cross_ff     <= '0;
         square_ff    <= '0;
         sel_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tm_ff        <= tm_in;
         dep_dec_ff   <= dep_dec_in;
         ind_dec_ff   <= ind_dec_in;
         jnt_dec_ff   <= jnt_dec_in;
         ready_ff     <= ready_in;
         intr_ff      <= intr_in;
         dep_px_ff    <= dep_px_in;
         ind_px_ff    <= ind_px_in;
         dep_mean_ff  <= dep_mean_in;
         ind_mean_ff  <= ind_mean_in;
         cross_ff     <= cross_in;
         square_ff    <= square_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      price_ff   <= price_in;
      old_ff     <= old_in;
      src_ff     <= src_in;
      pdi_ff     <= pdi_in;
      pii_ff     <= pii_in;
      acc_ff     <= acc_in;
      wk_ff      <= wk_in;
      xneg_ff    <= xneg_in;
      rneg_ff    <= rneg_in;
      jneg_ff    <= jneg_in;
      sneg_ff    <= sneg_in;
      jm_ff      <= jm_in;
      res_ff     <= res_in;
      rsp_res_ff <= rsp_res_in;
   end

   assign req_stall    = state_ff != S_IDLE;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_residual = rsp_res_ff;

endmodule
